/* hw/rtl/sid_pkg.sv */
// Shared types and constants for the signed integer divider.
// Used by sid_cell and signed_int32_divider_core; no dependencies.
package sid_pkg;

    // Default operand width
    localparam int DATA_WIDTH = 32;

    // Result status codes (carried on tuser)
    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_SAT  = 2'd1,
        ST_DIV0 = 2'd2
    } t_status;

    // Control broadcast to every cell of the chain
    typedef struct packed {
        logic load;  // capture operand magnitudes, clear remainder
        logic step;  // one shift-and-subtract iteration
    } t_cell_ctrl;

endpackage

/* hw/rtl/sid_cell.sv */
// One bit slice of the restoring divider chain: remainder, divisor and
// dividend/quotient bits plus the slice of the borrow chain.
// Depends on sid_pkg.
module sid_cell (
    input  logic                i_clk,
    input  sid_pkg::t_cell_ctrl i_ctrl,
    input  logic                i_ld_q,    // dividend magnitude bit
    input  logic                i_ld_dvs,  // divisor magnitude bit
    input  logic                i_rem,     // shifted-in remainder bit from lower cell
    input  logic                i_q,       // shifted-in quotient bit from lower cell
    input  logic                i_borrow,  // borrow from lower cell
    input  logic                i_take,    // subtract result accepted
    output logic                o_rem,
    output logic                o_q,
    output logic                o_borrow
);

    logic r_rem;
    logic r_q;
    logic r_dvs;
    logic w_diff;

    // Ripple subtract slice: shifted remainder minus divisor
    assign w_diff   = i_rem ^ r_dvs ^ i_borrow;
    assign o_borrow = (~i_rem & r_dvs) | (~(i_rem ^ r_dvs) & i_borrow);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_rem <= 1'b0;
            r_q   <= i_ld_q;
            r_dvs <= i_ld_dvs;
        end else if (i_ctrl.step) begin
            r_rem <= i_take ? w_diff : i_rem;
            r_q   <= i_q;
        end
    end

    assign o_rem = r_rem;
    assign o_q   = r_q;

endmodule

/* hw/rtl/signed_int32_divider_core.sv */
// Signed integer divider, truncating toward zero, built from a chain of
// bit-slice cells. Depends on sid_pkg and sid_cell.
//
// Usage:
//   Slave channel (i_s_*): one transfer carries dividend and divisor.
//   Master channel (o_m_*): one transfer per input carries the quotient,
//   with the status code on tuser (ok, saturated, divide by zero).
//   Quotients truncate toward zero. The most negative value divided by
//   minus one saturates to the largest positive value with status SAT.
//   A zero divisor returns a zero quotient with status DIV0.
// Timing:
//   The cell chain is loaded at the input transfer, then runs one
//   shift-and-subtract iteration per cycle until every quotient bit is
//   formed; the sign fix-up then writes the result into the output
//   register once it is free. A new input is accepted only after the
//   fix-up, as the single chain that handles one quotient bit per cycle
//   works on one division at a time.
// Reset and stall:
//   Synchronous active-low reset empties the block. The output register
//   holds its result until taken; a new input is accepted meanwhile and
//   the sign fix-up waits while the output register is still occupied.
module signed_int32_divider_core #(
    parameter int DATA_WIDTH = sid_pkg::DATA_WIDTH
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // slave side
    input  logic                                  i_s_tvalid,
    output logic                                  o_s_tready,
    // [DATA_WIDTH-1:0] dividend, [2*DATA_WIDTH-1:DATA_WIDTH] divisor, zero pad
    input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]     i_s_tdata,
    // master side
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    // [DATA_WIDTH-1:0] quotient, zero pad
    output logic [((DATA_WIDTH+7)/8)*8-1:0]       o_m_tdata,
    // [1:0] status
    output logic [1:0]                            o_m_tuser
);

    localparam int OUT_TDATA_W = ((DATA_WIDTH + 7) / 8) * 8;
    localparam int CNT_W       = $clog2(DATA_WIDTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_BUSY,
        S_FIX
    } t_state;

    t_state                  r_state;
    logic [CNT_W-1:0]        r_cnt;
    logic                    r_neg;        // operand signs differ
    logic                    r_div0;       // divisor was zero
    logic                    r_m_valid;
    logic [OUT_TDATA_W-1:0]  r_m_tdata;
    logic [1:0]              r_m_tuser;

    logic                    w_s_xfer;
    logic                    w_out_free;
    logic                    n_m_valid;
    logic [DATA_WIDTH-1:0]   w_dvd;
    logic [DATA_WIDTH-1:0]   w_dvs;
    logic [DATA_WIDTH-1:0]   w_dvd_mag;
    logic [DATA_WIDTH-1:0]   w_dvs_mag;
    sid_pkg::t_cell_ctrl     w_ctrl;
    logic                    w_take;
    logic [DATA_WIDTH-1:0]   w_rem;
    logic [DATA_WIDTH-1:0]   w_quo;
    logic [DATA_WIDTH:0]     w_borrow;
    logic [DATA_WIDTH-1:0]   n_quo;
    sid_pkg::t_status        n_status;

    assign o_s_tready = (r_state == S_IDLE);
    assign w_s_xfer   = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_m_valid || i_m_tready;

    // Output valid: set when the fix-up writes, cleared when taken
    assign n_m_valid = ((r_state == S_FIX) && w_out_free) || (r_m_valid && !i_m_tready);

    // Operand magnitudes for loading the chain
    assign w_dvd     = i_s_tdata[DATA_WIDTH-1:0];
    assign w_dvs     = i_s_tdata[2*DATA_WIDTH-1:DATA_WIDTH];
    assign w_dvd_mag = w_dvd[DATA_WIDTH-1] ? (~w_dvd + 1'b1) : w_dvd;
    assign w_dvs_mag = w_dvs[DATA_WIDTH-1] ? (~w_dvs + 1'b1) : w_dvs;

    assign w_ctrl.load = w_s_xfer;
    assign w_ctrl.step = (r_state == S_BUSY);

    // No borrow out of the top slice: shifted remainder >= divisor
    assign w_borrow[0] = 1'b0;
    assign w_take      = ~w_borrow[DATA_WIDTH];

    // Cell chain: remainder and quotient both shift up one slice per step;
    // the dividend MSB feeds the remainder, the new quotient bit enters at 0.
    for (genvar g = 0; g < DATA_WIDTH; g++) begin : g_cell
        logic w_rem_in;
        logic w_q_in;
        if (g == 0) begin : g_first
            assign w_rem_in = w_quo[DATA_WIDTH-1];
            assign w_q_in   = w_take;
        end else begin : g_rest
            assign w_rem_in = w_rem[g-1];
            assign w_q_in   = w_quo[g-1];
        end
        sid_cell u_cell (
            .i_clk    (i_clk),
            .i_ctrl   (w_ctrl),
            .i_ld_q   (w_dvd_mag[g]),
            .i_ld_dvs (w_dvs_mag[g]),
            .i_rem    (w_rem_in),
            .i_q      (w_q_in),
            .i_borrow (w_borrow[g]),
            .i_take   (w_take),
            .o_rem    (w_rem[g]),
            .o_q      (w_quo[g]),
            .o_borrow (w_borrow[g+1])
        );
    end

    // Sign restore and special cases
    always_comb begin
        n_quo    = w_quo;
        n_status = sid_pkg::ST_OK;
        if (r_div0) begin
            n_quo    = '0;
            n_status = sid_pkg::ST_DIV0;
        end else if (r_neg) begin
            n_quo = ~w_quo + 1'b1;
        end else if (w_quo[DATA_WIDTH-1]) begin
            n_quo    = {1'b0, {(DATA_WIDTH-1){1'b1}}};
            n_status = sid_pkg::ST_SAT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_m_valid <= n_m_valid;
            case (r_state)
                S_IDLE: begin
                    if (w_s_xfer) begin
                        r_state <= S_BUSY;
                        r_cnt   <= '0;
                        r_neg   <= w_dvd[DATA_WIDTH-1] ^ w_dvs[DATA_WIDTH-1];
                        r_div0  <= (w_dvs == '0);
                    end
                end
                S_BUSY: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(DATA_WIDTH - 1)) begin
                        r_state <= S_FIX;
                    end
                end
                S_FIX: begin
                    if (w_out_free) begin
                        r_state   <= S_IDLE;
                        r_m_tdata <= OUT_TDATA_W'(n_quo);
                        r_m_tuser <= n_status;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_tdata;
    assign o_m_tuser  = r_m_tuser;

    // Assertions
    a_load_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s_xfer |=> (r_state == S_BUSY) && (r_cnt == '0))
        else $error("input transfer did not start the iteration");

    a_fix_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIX) && w_out_free |=> o_m_tvalid && (r_state == S_IDLE))
        else $error("sign fix-up did not produce a result");

    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == sid_pkg::ST_SAT) |->
            (o_m_tdata[DATA_WIDTH-1:0] == {1'b0, {(DATA_WIDTH-1){1'b1}}}))
        else $error("saturated result is not the largest positive value");

    a_div0_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == sid_pkg::ST_DIV0) |->
            (o_m_tdata[DATA_WIDTH-1:0] == '0))
        else $error("divide by zero result is not zero");

endmodule
